// ----- hdl/drc_pkg.sv -----
`default_nettype none

package drc_pkg;

    // Default sizes of the table and of the stored numbers.
    localparam int DEF_MAX_ENTRIES    = 16;
    localparam int DEF_MAX_OBJECTIVES = 4;
    localparam int DEF_VALUE_WIDTH    = 32;

    // Fixed shape of the stream fields.
    localparam int FIELD_W     = 32;
    localparam int PORT_OBJ    = 4;
    localparam int IDX_W       = 4;
    localparam int OBJ_CNT_W   = 3;
    localparam int CFG_DATA_W  = 3;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_SENSE      = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OBJECTIVES = 1'd1;

    localparam logic [OBJ_CNT_W-1:0] OBJ_RESET = 3'd4;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_HIT      = 2'd2,
        ST_MISS     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic cap_query;
        logic set_ins;
        logic set_full;
        logic set_hit;
        logic set_miss;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic match;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- hdl/drc_ctrl.sv -----
`default_nettype none

module drc_ctrl #(
    parameter int MAX_ENTRIES = drc_pkg::DEF_MAX_ENTRIES,
    localparam int AW = $clog2(MAX_ENTRIES)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_action,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  drc_pkg::t_dp_sts      i_sts,
    output drc_pkg::t_cmd         o_cmd,
    output logic [AW-1:0]         o_addr,
    output logic [AW-1:0]         o_res_idx
);
    import drc_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_addr, n_addr;
    logic [AW-1:0] r_cmp_idx, n_cmp_idx;
    logic          r_pend, n_pend;
    logic          r_out_valid, n_out_valid;
    logic          accept, full, more, out_free, hit;
    t_cmd          cmd;

    assign full       = (r_count == CW'(MAX_ENTRIES));
    assign more       = (r_addr < r_count);
    assign out_free   = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign hit        = r_pend && i_sts.match;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd      = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_addr      <= n_addr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_addr    = r_addr;
        n_pend    = r_pend;
        n_cmp_idx = r_cmp_idx;
        cmd       = '0;
        o_addr    = r_count[AW-1:0];
        o_res_idx = r_count[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_action == ACT_INSERT) begin
                        if (full) begin
                            cmd.set_full = 1'b1;
                        end else begin
                            cmd.wr_en   = 1'b1;
                            cmd.set_ins = 1'b1;
                            n_count     = r_count + CW'(1);
                        end
                        n_state = S_DONE;
                    end else begin
                        cmd.cap_query = 1'b1;
                        n_addr        = '0;
                        n_pend        = 1'b0;
                        n_state       = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_addr    = r_addr[AW-1:0];
                o_res_idx = r_cmp_idx;
                if (hit) begin
                    cmd.set_hit = 1'b1;
                    n_pend      = 1'b0;
                    n_state     = S_DONE;
                end else if (more) begin
                    cmd.rd_en = 1'b1;
                    n_cmp_idx = r_addr[AW-1:0];
                    n_addr    = r_addr + CW'(1);
                    n_pend    = 1'b1;
                end else begin
                    cmd.set_miss = 1'b1;
                    n_pend       = 1'b0;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wr_en |-> !full)
        else $error("Table write issued while the table is full.");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("Entry count exceeds the table depth.");

    a_read_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rd_en |-> (r_addr < r_count))
        else $error("Scan read beyond the filled part of the table.");

    a_count_grows_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wr_en |=> (r_count == $past(r_count) + CW'(1)))
        else $error("Entry count did not advance after a table write.");

endmodule

`default_nettype wire

// ----- hdl/drc_datapath.sv -----
`default_nettype none

module drc_datapath #(
    parameter int MAX_ENTRIES    = drc_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_OBJECTIVES = drc_pkg::DEF_MAX_OBJECTIVES,
    parameter int VALUE_WIDTH    = drc_pkg::DEF_VALUE_WIDTH,
    localparam int AW = $clog2(MAX_ENTRIES)
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_cfg_we,
    input  wire logic [drc_pkg::CFG_INDEX_W-1:0]             i_cfg_index,
    input  wire logic [drc_pkg::CFG_DATA_W-1:0]              i_cfg_data,
    input  drc_pkg::t_cmd                                    i_cmd,
    output drc_pkg::t_dp_sts                                 o_sts,
    input  wire logic [AW-1:0]                               i_addr,
    input  wire logic [AW-1:0]                               i_res_idx,
    input  wire logic [drc_pkg::PORT_OBJ-1:0][drc_pkg::FIELD_W-1:0] i_bound,
    input  wire logic [drc_pkg::PORT_OBJ-1:0][drc_pkg::FIELD_W-1:0] i_value,
    input  wire logic                                        i_no_solution,
    output drc_pkg::t_status                                 o_status,
    output logic [drc_pkg::IDX_W-1:0]                        o_entry_index,
    output logic                                             o_hit_infeasible,
    output logic [drc_pkg::PORT_OBJ-1:0][drc_pkg::FIELD_W-1:0] o_value
);
    import drc_pkg::*;

    localparam int MO = MAX_OBJECTIVES;
    localparam int VW = VALUE_WIDTH;

    typedef struct packed {
        logic                  inf;
        logic [MO-1:0][VW-1:0] val;
        logic [MO-1:0][VW-1:0] bnd;
    } t_row;

    function automatic logic [VW-1:0] to_store(input logic [FIELD_W-1:0] f);
        logic signed [FIELD_W-1:0] sf;
        logic [63:0]               ext;
        sf  = f;
        ext = 64'(sf);
        return ext[VW-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] to_field(input logic [VW-1:0] v);
        logic signed [VW-1:0] sv;
        logic [63:0]          ext;
        sv  = v;
        ext = 64'(sv);
        return ext[FIELD_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] to_idx(input logic [AW-1:0] a);
        logic [AW+IDX_W-1:0] ext;
        ext = (AW + IDX_W)'(a);
        return ext[IDX_W-1:0];
    endfunction

    t_row                  r_mem [MAX_ENTRIES];
    t_row                  r_rd_row;
    t_row                  wr_row;
    logic [MO-1:0][VW-1:0] r_query;
    logic                  r_sense;
    logic [OBJ_CNT_W-1:0]  r_obj;
    logic [OBJ_CNT_W-1:0]  n_act;
    logic [MO-1:0]         lane_use, bnd_ok, val_ok;
    logic                  match;
    logic [PORT_OBJ-1:0][FIELD_W-1:0] hit_val;

    t_status                          r_res_status;
    logic [IDX_W-1:0]                 r_res_idx;
    logic                             r_res_inf;
    logic [PORT_OBJ-1:0][FIELD_W-1:0] r_res_val;
    t_status                          r_out_status;
    logic [IDX_W-1:0]                 r_out_idx;
    logic                             r_out_inf;
    logic [PORT_OBJ-1:0][FIELD_W-1:0] r_out_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sense <= 1'b0;
            r_obj   <= OBJ_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SENSE:      r_sense <= i_cfg_data[0];
                CFG_OBJECTIVES: r_obj   <= i_cfg_data;
            endcase
        end
    end

    // A count above the lane count acts as the lane count.
    assign n_act = (r_obj > OBJ_CNT_W'(MO)) ? OBJ_CNT_W'(MO) : r_obj;

    always_comb begin
        wr_row.inf = i_no_solution;
        match      = 1'b1;
        hit_val    = '0;
        for (int i = 0; i < MO; i++) begin
            lane_use[i]   = OBJ_CNT_W'(i) < n_act;
            wr_row.bnd[i] = lane_use[i] ? to_store(i_bound[i]) : '0;
            wr_row.val[i] = (lane_use[i] && !i_no_solution) ? to_store(i_value[i]) : '0;
            if (r_sense) begin
                bnd_ok[i] = $signed(r_rd_row.bnd[i]) <= $signed(r_query[i]);
                val_ok[i] = $signed(r_rd_row.val[i]) >= $signed(r_query[i]);
            end else begin
                bnd_ok[i] = $signed(r_rd_row.bnd[i]) >= $signed(r_query[i]);
                val_ok[i] = $signed(r_rd_row.val[i]) <= $signed(r_query[i]);
            end
            if (lane_use[i] && !(bnd_ok[i] && (r_rd_row.inf || val_ok[i]))) begin
                match = 1'b0;
            end
            if (lane_use[i] && !r_rd_row.inf) begin
                hit_val[i] = to_field(r_rd_row.val[i]);
            end
        end
    end

    assign o_sts.match = match;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_addr] <= wr_row;
        end
        if (i_cmd.rd_en) begin
            r_rd_row <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_query) begin
            for (int i = 0; i < MO; i++) begin
                r_query[i] <= to_store(i_bound[i]);
            end
        end
        if (i_cmd.set_ins) begin
            r_res_status <= ST_INSERTED;
            r_res_idx    <= to_idx(i_res_idx);
            r_res_inf    <= 1'b0;
            r_res_val    <= '0;
        end
        if (i_cmd.set_full) begin
            r_res_status <= ST_FULL;
            r_res_idx    <= '0;
            r_res_inf    <= 1'b0;
            r_res_val    <= '0;
        end
        if (i_cmd.set_hit) begin
            r_res_status <= ST_HIT;
            r_res_idx    <= to_idx(i_res_idx);
            r_res_inf    <= r_rd_row.inf;
            r_res_val    <= hit_val;
        end
        if (i_cmd.set_miss) begin
            r_res_status <= ST_MISS;
            r_res_idx    <= '0;
            r_res_inf    <= 1'b0;
            r_res_val    <= '0;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_idx    <= r_res_idx;
            r_out_inf    <= r_res_inf;
            r_out_val    <= r_res_val;
        end
    end

    assign o_status         = r_out_status;
    assign o_entry_index    = r_out_idx;
    assign o_hit_infeasible = r_out_inf;
    assign o_value          = r_out_val;

    a_one_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.set_ins, i_cmd.set_full, i_cmd.set_hit, i_cmd.set_miss}))
        else $error("More than one result source selected in one cycle.");

    a_infeasible_hit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.set_hit |=> (!r_res_inf || (r_res_val == '0)))
        else $error("Infeasible hit carries nonzero values.");

    a_load_copies_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> (r_out_status == $past(r_res_status)))
        else $error("Output status does not match the staged result.");

endmodule

`default_nettype wire

// ----- hdl/dominance_relaxation_cache_top.sv -----
// Dominance relaxation cache: a table of solved subproblems with insert and lookup.
// Input stream (s_axis): one transaction per request. tuser[0] selects insert (0) or
// lookup (1); tdata carries four bounds, four solution values and the infeasible flag.
// Output stream (m_axis): exactly one transaction per request, in request order.
// tuser carries the status (inserted, full, hit, miss); tdata carries the entry index,
// the infeasible mark of a hit and the four values of a feasible hit.
// Configuration: a plain write port, register 0 selects maximize sense and register 1
// the number of objectives in use; write it only while no request is in flight.
// An accepted insert sets o_m_tvalid once its result is loaded into the output register.
// A lookup reads the table one entry per cycle through the registered memory port, so over
// a table holding N entries a miss shows once all N are read, and a hit once entry k matches.
// The block takes one request at a time: the next request is taken only after the
// result of the last one is loaded into the output register.
// Reset clears the entry count and the configuration (minimize sense, four
// objectives); table contents are not cleared and only filled entries are ever read.
// When the receiver stalls, the result holds in the output register; the next request
// is still accepted and computed, and waits until that register is free.

`default_nettype none

module dominance_relaxation_cache_top #(
    parameter int MAX_ENTRIES    = drc_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_OBJECTIVES = drc_pkg::DEF_MAX_OBJECTIVES,
    parameter int VALUE_WIDTH    = drc_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [drc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [drc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // tdata fields from bit 0 up: bound_0, bound_1, bound_2, bound_3,
    // value_0, value_1, value_2, value_3, no_solution, zero pad.
    input  wire logic [263:0]                       i_s_tdata,
    // tuser fields: action.
    input  wire logic [0:0]                         i_s_tuser,
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // tdata fields from bit 0 up: entry_index, hit_infeasible,
    // out_value_0, out_value_1, out_value_2, out_value_3, zero pad.
    output logic [135:0]                            o_m_tdata,
    // tuser fields: status.
    output logic [1:0]                              o_m_tuser
);
    import drc_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);

    t_cmd                             cmd;
    t_dp_sts                          sts;
    logic [AW-1:0]                    addr, res_idx;
    logic [PORT_OBJ-1:0][FIELD_W-1:0] in_bound, in_value, out_value;
    t_status                          out_status;
    logic [IDX_W-1:0]                 out_idx;
    logic                             out_inf;

    // Unpack the request: lane 0 sits in the lowest bits of each group.
    assign in_bound = i_s_tdata[127:0];
    assign in_value = i_s_tdata[255:128];

    drc_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .i_action    (i_s_tuser[0]),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_addr      (addr),
        .o_res_idx   (res_idx)
    );

    drc_datapath #(
        .MAX_ENTRIES    (MAX_ENTRIES),
        .MAX_OBJECTIVES (MAX_OBJECTIVES),
        .VALUE_WIDTH    (VALUE_WIDTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_addr           (addr),
        .i_res_idx        (res_idx),
        .i_bound          (in_bound),
        .i_value          (in_value),
        .i_no_solution    (i_s_tdata[256]),
        .o_status         (out_status),
        .o_entry_index    (out_idx),
        .o_hit_infeasible (out_inf),
        .o_value          (out_value)
    );

    // Pack the result: index, infeasible mark, then the four values, then padding.
    assign o_m_tdata = {3'b000, out_value, out_inf, out_idx};
    assign o_m_tuser = out_status;

endmodule

`default_nettype wire
